@@ src/lnpa_pkg.sv @@
// Package for the linked node pool allocator.
// Holds the operation codes, the sequencer states and shared constants.
package lnpa_pkg;

    localparam int unsigned NODES_DEF     = 256;
    localparam int unsigned KEY_BITS_DEF  = 16;
    localparam int unsigned DATA_BITS_DEF = 32;

    // Operation codes carried in func.
    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_PUT   = 2'd2,
        FUNC_GET   = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC_RD,
        S_WALK_RD,
        S_WALK_CHK,
        S_FIND_RD,
        S_FIND_CHK,
        S_DONE
    } state_t;

endpackage

@@ src/lnpa_if.sv @@
// Valid/ready channel interface for the allocator.
// Depends on nothing; the payload widths are fixed by the item format.
interface lnpa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  base_addr;
    logic [15:0] key;
    logic signed [31:0] value;
    logic [8:0]  run_count;
    logic        first;
    modport source (output valid, func, base_addr, key, value, run_count, first,
                    input ready);
    modport sink   (input valid, func, base_addr, key, value, run_count, first,
                    output ready);
endinterface

interface lnpa_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  chain_addr;
    logic signed [31:0] read_value;
    logic [8:0]  free_nodes;
    modport source (output valid, status, chain_addr, read_value, free_nodes,
                    input ready);
    modport sink   (input valid, status, chain_addr, read_value, free_nodes,
                    output ready);
endinterface

@@ src/lnpa_node_mem.sv @@
// Node memory: link, key and data words, one synchronous read port and
// one write port per field. Depends on lnpa_pkg.
module lnpa_node_mem
    import lnpa_pkg::*;
#(
    parameter int unsigned NODES     = NODES_DEF,
    parameter int unsigned KEY_BITS  = KEY_BITS_DEF,
    parameter int unsigned DATA_BITS = DATA_BITS_DEF,
    localparam int unsigned AW = $clog2(NODES),
    localparam int unsigned LW = AW + 1
)(
    input  logic                 clk,
    input  logic [AW-1:0]        rd_addr,
    output logic [LW-1:0]        rd_link,
    output logic [KEY_BITS-1:0]  rd_key,
    output logic [DATA_BITS-1:0] rd_data,
    input  logic                 link_we,
    input  logic [AW-1:0]        link_addr,
    input  logic [LW-1:0]        link_wdata,
    input  logic                 key_we,
    input  logic [AW-1:0]        key_addr,
    input  logic [KEY_BITS-1:0]  key_wdata,
    input  logic                 data_we,
    input  logic [AW-1:0]        data_addr,
    input  logic [DATA_BITS-1:0] data_wdata
);

    logic [LW-1:0]        link_mem [NODES];
    logic [KEY_BITS-1:0]  key_mem  [NODES];
    logic [DATA_BITS-1:0] data_mem [NODES];

    // Writes.
    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_addr] <= link_wdata;
        if (key_we)
            key_mem[key_addr] <= key_wdata;
        if (data_we)
            data_mem[data_addr] <= data_wdata;
    end

    // Registered reads.
    always_ff @(posedge clk)
    begin
        rd_link <= link_mem[rd_addr];
        rd_key  <= key_mem[rd_addr];
        rd_data <= data_mem[rd_addr];
    end

endmodule

@@ src/linked_node_pool_allocator.sv @@
// Top level of the linked node pool allocator: sequencer and pool state.
// Depends on lnpa_pkg, lnpa_if and lnpa_node_mem.
//
// Usage: items arrive on the in channel, one transaction per operation, and
// each produces exactly one result transaction on the out channel.
// The first element of an allocation run reads the free head and takes it in
// S_ALLOC_RD; each later element also passes S_WALK_CHK, which links the old
// tail to the new node. A failed or ignored element goes straight to S_DONE.
// Free walks the chain to its tail, one node memory read per node, through
// S_WALK_RD and S_WALK_CHK. Put and get walk through S_FIND_RD and S_FIND_CHK
// until a key matches; an address outside the pool goes straight to S_DONE.
// The node read is registered, and at most NODES nodes are walked.
// After reset the block clears the node memory and threads the free list;
// in is not ready during that pass. The result sits in an output register
// until taken; while the receiver stalls, no new item is accepted. One item
// is worked on at a time.
module linked_node_pool_allocator
    import lnpa_pkg::*;
#(
    parameter int unsigned NODES     = NODES_DEF,
    parameter int unsigned KEY_BITS  = KEY_BITS_DEF,
    parameter int unsigned DATA_BITS = DATA_BITS_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    lnpa_in_if.sink      in_ch,
    lnpa_out_if.source   out_ch
);

    localparam int unsigned AW = $clog2(NODES);
    localparam int unsigned LW = AW + 1;
    localparam logic [LW-1:0] NIL = LW'(NODES);

    state_t state_reg, state_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] free_total_reg, free_total_next;
    logic [LW-1:0] run_left_reg, run_left_next;
    logic [AW-1:0] run_head_reg, run_head_next;
    logic [LW-1:0] run_tail_reg, run_tail_next;
    logic          run_failed_reg, run_failed_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [LW-1:0] steps_reg, steps_next;
    func_t         func_reg, func_next;
    logic [AW-1:0] base_reg, base_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [DATA_BITS-1:0] val_reg, val_next;
    logic          first_reg, first_next;
    logic [1:0]    st_reg, st_next;
    logic [7:0]    chain_reg, chain_next;
    logic [31:0]   rv_reg, rv_next;

    logic [AW-1:0] rd_addr;
    logic [LW-1:0] rd_link;
    logic [KEY_BITS-1:0] rd_key;
    logic [DATA_BITS-1:0] rd_data;
    logic link_we, key_we, data_we;
    logic [AW-1:0] link_addr, key_addr, data_addr;
    logic [LW-1:0] link_wdata;
    logic [KEY_BITS-1:0] key_wdata;
    logic [DATA_BITS-1:0] data_wdata;

    lnpa_node_mem #(.NODES(NODES), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)) u_mem (
        .clk(clk), .rd_addr(rd_addr), .rd_link(rd_link), .rd_key(rd_key),
        .rd_data(rd_data), .link_we(link_we), .link_addr(link_addr),
        .link_wdata(link_wdata), .key_we(key_we), .key_addr(key_addr),
        .key_wdata(key_wdata), .data_we(data_we), .data_addr(data_addr),
        .data_wdata(data_wdata)
    );

    logic in_fire;
    logic in_base_ok;
    logic [LW:0] sum_free;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_DONE);
    assign out_ch.status     = st_reg;
    assign out_ch.chain_addr = chain_reg;
    assign out_ch.read_value = rv_reg;
    assign out_ch.free_nodes = 9'(free_total_reg);
    assign in_base_ok = (32'(in_ch.base_addr) < NODES);
    assign sum_free = {1'b0, free_total_reg} + {1'b0, steps_reg};

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            free_head_reg  <= '0;
            free_total_reg <= NIL;
            run_left_reg   <= '0;
            run_head_reg   <= '0;
            run_tail_reg   <= '0;
            run_failed_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            free_head_reg  <= free_head_next;
            free_total_reg <= free_total_next;
            run_left_reg   <= run_left_next;
            run_head_reg   <= run_head_next;
            run_tail_reg   <= run_tail_next;
            run_failed_reg <= run_failed_next;
        end
    end

    // Working payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        steps_reg <= steps_next;
        func_reg  <= func_next;
        base_reg  <= base_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        first_reg <= first_next;
        st_reg    <= st_next;
        chain_reg <= chain_next;
        rv_reg    <= rv_next;
    end

    // Sequencer: next state, memory accesses and results.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        free_head_next  = free_head_reg;
        free_total_next = free_total_reg;
        run_left_next   = run_left_reg;
        run_head_next   = run_head_reg;
        run_tail_next   = run_tail_reg;
        run_failed_next = run_failed_reg;
        ptr_next   = ptr_reg;
        steps_next = steps_reg;
        func_next  = func_reg;
        base_next  = base_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        first_next = first_reg;
        st_next    = st_reg;
        chain_next = chain_reg;
        rv_next    = rv_reg;
        rd_addr    = ptr_reg;
        link_we = 1'b0; link_addr = ptr_reg; link_wdata = NIL;
        key_we  = 1'b0; key_addr  = ptr_reg; key_wdata  = key_reg;
        data_we = 1'b0; data_addr = ptr_reg; data_wdata = val_reg;
        case (state_reg)
            S_INIT:
            begin
                // Clearing pass: thread the free list and zero keys and data.
                link_we = 1'b1; key_we = 1'b1; data_we = 1'b1;
                link_addr = cnt_reg[AW-1:0]; key_addr = cnt_reg[AW-1:0];
                data_addr = cnt_reg[AW-1:0];
                link_wdata = cnt_reg + 1'b1;
                key_wdata = '0; data_wdata = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == NIL - 1'b1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    func_next  = func_t'(in_ch.func);
                    base_next  = AW'(in_ch.base_addr);
                    key_next   = KEY_BITS'(in_ch.key);
                    val_next   = DATA_BITS'(in_ch.value);
                    first_next = in_ch.first;
                    st_next    = ST_OK;
                    chain_next = '0;
                    rv_next    = '0;
                    steps_next = LW'(1);
                    ptr_next   = AW'(in_ch.base_addr);
                    rd_addr    = AW'(in_ch.base_addr);
                    state_next = S_DONE;
                    case (func_t'(in_ch.func))
                        FUNC_ALLOC:
                        begin
                            ptr_next = free_head_reg[AW-1:0];
                            rd_addr  = free_head_reg[AW-1:0];
                            if (in_ch.first)
                            begin
                                if (in_ch.run_count == '0
                                    || 32'(in_ch.run_count) > 32'(free_total_reg)
                                    || free_head_reg >= NIL)
                                begin
                                    st_next = ST_NOSPACE;
                                    run_failed_next = 1'b1;
                                    run_left_next = (in_ch.run_count == '0) ? '0
                                        : LW'(in_ch.run_count - 1'b1);
                                end
                                else
                                begin
                                    run_failed_next = 1'b0;
                                    run_left_next = LW'(in_ch.run_count);
                                    run_head_next = free_head_reg[AW-1:0];
                                    state_next = S_ALLOC_RD;
                                end
                            end
                            else if (run_left_reg == '0 || run_failed_reg)
                            begin
                                st_next = ST_IGNORED;
                                if (run_left_reg != '0)
                                    run_left_next = run_left_reg - 1'b1;
                            end
                            else if (free_head_reg >= NIL || free_total_reg == '0)
                            begin
                                st_next = ST_NOSPACE;
                                run_failed_next = 1'b1;
                                run_left_next = run_left_reg - 1'b1;
                            end
                            else
                                state_next = S_ALLOC_RD;
                        end
                        FUNC_FREE:
                        begin
                            if (in_base_ok)
                                state_next = S_WALK_RD;
                        end
                        default:
                        begin
                            if (in_base_ok)
                                state_next = S_FIND_RD;
                        end
                    endcase
                end
            end
            S_ALLOC_RD:
            begin
                // rd_link holds the next free node; take the head node.
                free_head_next  = rd_link;
                free_total_next = free_total_reg - 1'b1;
                key_we = 1'b1; key_wdata = key_reg;
                link_we = 1'b1; link_wdata = NIL;
                run_tail_next = {1'b0, ptr_reg};
                run_left_next = run_left_reg - 1'b1;
                chain_next = 8'(run_head_reg);
                state_next = S_DONE;
                if (!first_reg && run_tail_reg < NIL)
                    state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    // Second link write of the element: link the old tail to the new node.
                    link_we = 1'b1;
                    link_addr = cnt_reg[AW-1:0];
                    link_wdata = {1'b0, ptr_reg};
                    state_next = S_DONE;
                end
                else if (rd_link < NIL && steps_reg < NIL)
                begin
                    ptr_next = rd_link[AW-1:0];
                    rd_addr  = rd_link[AW-1:0];
                    steps_next = steps_reg + 1'b1;
                    state_next = S_WALK_RD;
                end
                else
                begin
                    link_we = 1'b1; link_wdata = free_head_reg;
                    free_head_next = {1'b0, base_reg};
                    free_total_next = (sum_free > (LW+1)'(NODES)) ? NIL
                        : LW'(sum_free);
                    state_next = S_DONE;
                end
            end
            S_WALK_RD:
                state_next = S_WALK_CHK;
            S_FIND_RD:
                state_next = S_FIND_CHK;
            S_FIND_CHK:
            begin
                if (rd_key == key_reg)
                begin
                    if (func_reg == FUNC_PUT)
                        data_we = 1'b1;
                    else
                        rv_next = 32'($signed(rd_data));
                    state_next = S_DONE;
                end
                else if (rd_link < NIL && steps_reg < NIL)
                begin
                    ptr_next = rd_link[AW-1:0];
                    rd_addr  = rd_link[AW-1:0];
                    steps_next = steps_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // Old tail address rides in cnt_reg for the linking cycle.
        if (state_reg == S_ALLOC_RD)
            cnt_next = run_tail_reg;
    end

    // A result is offered only after the clearing pass has finished.
    a_no_out_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INIT |-> !out_ch.valid)
        else $error("result offered during clearing pass");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= NIL)
        else $error("free count above pool size");
    a_accept_leads_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ch.ready)
        else $error("second item accepted while one is in work");
    a_alloc_dec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ALLOC_RD |=> free_total_reg == $past(free_total_reg) - 1'b1)
        else $error("allocation did not take one node");

endmodule

@@ tb/tb_linked_node_pool_allocator.sv @@
// Testbench for the linked node pool allocator: directed and random transactions
// are checked against an in-bench model of the pool. Depends on lnpa_pkg, lnpa_if
// and the allocator RTL.
module tb_linked_node_pool_allocator;
    import lnpa_pkg::*;

    localparam int unsigned POOL = 256;
    localparam int unsigned NULL_LINK = POOL;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        func_t       func;
        logic [7:0]  base_addr;
        logic [15:0] key;
        logic [31:0] value;
        logic [8:0]  run_count;
        logic        first;
    } op_item_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  chain_addr;
        logic [31:0] read_value;
        logic [8:0]  free_nodes;
    } pool_result_t;

    logic clk;
    logic rst_n;

    lnpa_in_if  in_ch ();
    lnpa_out_if out_ch ();

    linked_node_pool_allocator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Model of the pool state.
    logic [8:0]  link_mem [POOL];
    logic [15:0] key_mem [POOL];
    logic [31:0] data_mem [POOL];
    int unsigned free_head;
    int unsigned free_count;
    int unsigned run_left;
    int unsigned run_head;
    int unsigned run_tail;
    bit          run_failed;

    op_item_t     pending_ops [$];
    pool_result_t expected_results [$];
    int unsigned  mismatch_count = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  in_gap;
    int unsigned  out_gap;
    int unsigned  hold_off;
    bit           hold_done;

    always #4 clk = ~clk;

    function automatic void reset_pool();
        for (int i = 0; i < POOL; i++)
        begin
            link_mem[i] = 9'(i + 1);
            key_mem[i]  = '0;
            data_mem[i] = '0;
        end
        free_head  = 0;
        free_count = POOL;
        run_left   = 0;
        run_head   = 0;
        run_tail   = 0;
        run_failed = 0;
    endfunction

    // First node of the chain at start whose key matches, or null.
    function automatic int unsigned search_chain(int unsigned start, logic [15:0] k);
        int unsigned node;
        int unsigned steps;
        node  = start;
        steps = 0;
        while (node < POOL && steps < POOL)
        begin
            if (key_mem[node] == k)
                return node;
            node = link_mem[node];
            steps++;
        end
        return NULL_LINK;
    endfunction

    // Applies one operation to the model and returns the result it should give.
    function automatic pool_result_t apply_op(op_item_t op);
        pool_result_t res;
        bit           take;
        int unsigned  node;
        int unsigned  walked;
        res  = '{status: ST_OK, chain_addr: 8'd0, read_value: 32'd0, free_nodes: 9'd0};
        take = 0;
        case (op.func)
            FUNC_ALLOC:
            begin
                if (op.first)
                begin
                    if (op.run_count == 0 || op.run_count > free_count || free_head >= POOL)
                    begin
                        res.status = ST_NOSPACE;
                        run_failed = 1;
                        run_left   = (op.run_count != 0) ? op.run_count - 1 : 0;
                    end
                    else
                    begin
                        run_failed = 0;
                        run_left   = op.run_count;
                        run_head   = free_head;
                        take       = 1;
                    end
                end
                else if (run_left == 0 || run_failed)
                begin
                    res.status = ST_IGNORED;
                    if (run_left != 0)
                        run_left--;
                end
                else if (free_head >= POOL || free_count == 0)
                begin
                    res.status = ST_NOSPACE;
                    run_failed = 1;
                    run_left--;
                end
                else
                    take = 1;
                if (take)
                begin
                    node          = free_head;
                    free_head     = link_mem[node];
                    free_count--;
                    key_mem[node]  = op.key;
                    link_mem[node] = 9'(NULL_LINK);
                    if (!op.first && run_tail < POOL)
                        link_mem[run_tail] = 9'(node);
                    run_tail = node;
                    run_left--;
                    res.chain_addr = 8'(run_head);
                end
            end
            FUNC_FREE:
            begin
                node   = op.base_addr;
                walked = 1;
                while (link_mem[node] < POOL && walked < POOL)
                begin
                    node = link_mem[node];
                    walked++;
                end
                link_mem[node] = 9'(free_head);
                free_head      = op.base_addr;
                free_count     = (free_count + walked > POOL) ? POOL : free_count + walked;
            end
            FUNC_PUT:
            begin
                node = search_chain(op.base_addr, op.key);
                if (node < POOL)
                    data_mem[node] = op.value;
            end
            default:
            begin
                node = search_chain(op.base_addr, op.key);
                if (node < POOL)
                    res.read_value = data_mem[node];
            end
        endcase
        res.free_nodes = 9'(free_count);
        return res;
    endfunction

    function automatic op_item_t make_op(func_t f, int unsigned base, int unsigned k,
                                         logic [31:0] v, int unsigned cnt,
                                         int unsigned fst);
        op_item_t op;
        op.func      = f;
        op.base_addr = 8'(base);
        op.key       = 16'(k);
        op.value     = v;
        op.run_count = 9'(cnt);
        op.first     = 1'(fst);
        return op;
    endfunction

    // Queues an allocation run of elems elements with random keys; the first carries cnt.
    task automatic queue_run(int unsigned cnt, int unsigned elems);
        for (int i = 0; i < elems; i++)
            pending_ops.push_back(make_op(FUNC_ALLOC, $urandom, $urandom_range(0, 7),
                                          $urandom, (i == 0) ? cnt : $urandom, i == 0));
    endtask

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    endfunction

    function automatic bit apply_and_store(op_item_t op);
        expected_results.push_back(apply_op(op));
        return 1;
    endfunction

    // Driver: offers the next pending operation after a random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.func      <= FUNC_ALLOC;
            in_ch.base_addr <= '0;
            in_ch.key       <= '0;
            in_ch.value     <= '0;
            in_ch.run_count <= '0;
            in_ch.first     <= 1'b0;
            in_gap          <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                void'(apply_and_store(pending_ops.pop_front()));
            if (in_ch.valid && !in_ch.ready)
                ;
            else if (in_gap != 0)
            begin
                in_gap      <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (pending_ops.size() != 0)
            begin
                in_ch.valid     <= 1'b1;
                in_ch.func      <= pending_ops[0].func;
                in_ch.base_addr <= pending_ops[0].base_addr;
                in_ch.key       <= pending_ops[0].key;
                in_ch.value     <= pending_ops[0].value;
                in_ch.run_count <= pending_ops[0].run_count;
                in_ch.first     <= pending_ops[0].first;
                in_gap          <= pick_gap();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Long hold-off: started once traffic is flowing, counted down here.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off  <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && expected_results.size() > 0)
        begin
            hold_off  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_off != 0)
            hold_off <= hold_off - 1;
    end

    // Receiver: random stalls plus the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap      <= 0;
        end
        else if (hold_off != 0)
            out_ch.ready <= 1'b0;
        else if (out_gap != 0)
        begin
            out_ch.ready <= 1'b0;
            out_gap      <= out_gap - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (out_ch.valid && out_ch.ready)
                out_gap <= pick_gap();
        end
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        pool_result_t exp_res;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d free_nodes=%0d", $time,
                         out_ch.status, out_ch.free_nodes);
                mismatch_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (out_ch.status !== exp_res.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_res.status, out_ch.status);
                    mismatch_count++;
                end
                if (out_ch.chain_addr !== exp_res.chain_addr)
                begin
                    $display("%0t: chain_addr expected %0d actual %0d", $time,
                             exp_res.chain_addr, out_ch.chain_addr);
                    mismatch_count++;
                end
                if (out_ch.read_value !== exp_res.read_value)
                begin
                    $display("%0t: read_value expected %0h actual %0h", $time,
                             exp_res.read_value, out_ch.read_value);
                    mismatch_count++;
                end
                if (out_ch.free_nodes !== exp_res.free_nodes)
                begin
                    $display("%0t: free_nodes expected %0d actual %0d", $time,
                             exp_res.free_nodes, out_ch.free_nodes);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no transaction.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned c;
        clk   = 1'b0;
        rst_n = 1'b0;
        reset_pool();

        // Directed: key/value extremes, every function, and the special cases.
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 16'hFFFF, 0, 3, 1));
        pending_ops.push_back(make_op(FUNC_ALLOC, 8'hFF, 16'h0000, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 16'h8001, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_PUT, 0, 16'h8001, 32'h8000_0000, 0, 0));
        pending_ops.push_back(make_op(FUNC_PUT, 0, 16'hFFFF, 32'h7FFF_FFFF, 0, 0));
        pending_ops.push_back(make_op(FUNC_GET, 0, 16'h8001, 32'hFFFF_FFFF, 0, 0));
        pending_ops.push_back(make_op(FUNC_GET, 0, 16'hFFFF, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_GET, 0, 16'h1234, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 16'h5555, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 1, 0, 0, 1));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 1, 0, 9'h1FF, 1));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 2, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 3, 0, 4, 1));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 4, 0, 2, 1));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 5, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_FREE, 3, 0, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_FREE, 3, 0, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_FREE, 0, 0, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 6, 0, 256, 1));
        pending_ops.push_back(make_op(FUNC_GET, 8'hFF, 16'h0000, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 7, 0, 1, 1));
        pending_ops.push_back(make_op(FUNC_FREE, 0, 0, 0, 0, 0));
        pending_ops.push_back(make_op(FUNC_ALLOC, 0, 8, 0, 1, 1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Random: mostly short runs, mixed with puts/gets/frees on low nodes and fully random items.
        while (pending_ops.size() < 950)
        begin
            c = $urandom_range(0, 9);
            if (c < 4)
            begin
                c = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 256)
                                                 : $urandom_range(1, 6);
                if (c > 12)
                    queue_run(c, $urandom_range(1, 4));
                else
                    queue_run(c, ($urandom_range(0, 7) == 0) ? $urandom_range(0, c + 1) : c);
            end
            else if (c < 8)
                pending_ops.push_back(make_op(func_t'($urandom_range(2, 3)),
                                              $urandom_range(0, 15), $urandom_range(0, 7),
                                              $urandom, $urandom, $urandom));
            else if (c == 8)
                pending_ops.push_back(make_op(FUNC_FREE, $urandom_range(0, 31), $urandom,
                                              $urandom, $urandom, $urandom));
            else
                pending_ops.push_back(make_op(func_t'($urandom_range(0, 3)), $urandom,
                                              $urandom, $urandom, $urandom, $urandom));
        end

        wait (pending_ops.size() == 0 && !in_ch.valid);
        wait (expected_results.size() == 0);
        repeat (600) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
